/* src/rmst_pkg.sv */
`default_nettype none

package rmst_pkg;

  // Default sizing of the tree.
  localparam int LEAVES_DEF     = 1024;
  localparam int VALUE_BITS_DEF = 31;

  // Fixed field widths of the request, result and configuration ports.
  localparam int COMMAND_W = 1;
  localparam int LEFT_W    = 10;
  localparam int RIGHT_W   = 11;
  localparam int WVAL_W    = 31;
  localparam int OUT_W     = 31;
  localparam int USED_W    = 11;

  // Leaf count in use after reset.
  localparam logic [USED_W-1:0] USED_LEAVES_RESET = 11'd1024;

  // Request command codes.
  localparam logic [COMMAND_W-1:0] CMD_UPDATE = 1'b0;
  localparam logic [COMMAND_W-1:0] CMD_QUERY  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_UPD_READ,
    ST_UPD_WRITE,
    ST_Q_LO,
    ST_Q_HI,
    ST_Q_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load_in;
    logic q_init;
    logic upd_leaf;
    logic upd_read;
    logic upd_write;
    logic q_lo;
    logic q_hi;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic upd_skip;
    logic p_root;
    logic range_empty;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

/* src/rmst_ctrl.sv */
`default_nettype none

module rmst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rmst_pkg::ctrl_status_t status,
  output rmst_pkg::ctrl_cmd_t    cmd
);
  import rmst_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing sweep of the node memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.is_query) begin
          state_next = ST_Q_LO;
        end else if (status.upd_skip) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_UPD_READ;
        end
      end
      ST_UPD_READ: begin
        if (status.p_root) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_UPD_WRITE;
        end
      end
      ST_UPD_WRITE: begin
        state_next = ST_UPD_READ;
      end
      ST_Q_LO: begin
        if (status.range_empty) begin
          state_next = ST_Q_DONE;
        end else begin
          state_next = ST_Q_HI;
        end
      end
      ST_Q_HI: begin
        state_next = ST_Q_LO;
      end
      ST_Q_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic: one group of datapath commands per state.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_DISPATCH: begin
        cmd.q_init   = status.is_query;
        cmd.upd_leaf = !status.is_query && !status.upd_skip;
      end
      ST_UPD_READ: begin
        cmd.upd_read = !status.p_root;
      end
      ST_UPD_WRITE: begin
        cmd.upd_write = 1'b1;
      end
      ST_Q_LO: begin
        cmd.q_lo = !status.range_empty;
      end
      ST_Q_HI: begin
        cmd.q_hi = 1'b1;
      end
      ST_Q_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rmst_datapath.sv */
`default_nettype none

module rmst_datapath #(
  parameter int LEAVES     = rmst_pkg::LEAVES_DEF,
  parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rmst_pkg::USED_W-1:0]     cfg_wr_data,
  input  logic [rmst_pkg::COMMAND_W-1:0]  command,
  input  logic [rmst_pkg::LEFT_W-1:0]     left_index,
  input  logic [rmst_pkg::RIGHT_W-1:0]    right_bound,
  input  logic [rmst_pkg::WVAL_W-1:0]     write_value,
  input  rmst_pkg::ctrl_cmd_t             cmd,
  output rmst_pkg::ctrl_status_t          status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [rmst_pkg::OUT_W-1:0]      max_value
);
  import rmst_pkg::*;

  localparam int NODE_COUNT = 2 * LEAVES;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  // Range pointers may reach 2n, one past the last node.
  localparam int POS_W      = ADDR_W + 1;
  localparam int CMP_W      = (POS_W > USED_W) ? POS_W : USED_W;
  localparam int WIDE_W     = (VALUE_BITS > WVAL_W) ? VALUE_BITS : WVAL_W;

  // Configuration and captured request.
  logic [USED_W-1:0]    used_leaves;
  logic [COMMAND_W-1:0] op_cmd;
  logic [LEFT_W-1:0]    op_left;
  logic [RIGHT_W-1:0]   op_right;
  logic [WVAL_W-1:0]    op_value;

  // Walk registers.
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     p;
  logic [VALUE_BITS-1:0] cur;
  logic [POS_W-1:0]      lo;
  logic [POS_W-1:0]      hi;
  logic [VALUE_BITS-1:0] best;
  logic                  pend;

  // Node memory ports.
  logic [VALUE_BITS-1:0] mem [NODE_COUNT];
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [VALUE_BITS-1:0] rdata;

  // Derived values.
  logic [CMP_W-1:0]      used_w;
  logic [CMP_W-1:0]      n_w;
  logic [CMP_W-1:0]      left_w;
  logic [CMP_W-1:0]      right_w;
  logic [CMP_W-1:0]      lo_clamp;
  logic [CMP_W-1:0]      hi_clamp;
  logic [POS_W-1:0]      n_pos;
  logic [POS_W-1:0]      lo_start;
  logic [POS_W-1:0]      hi_start;
  logic [POS_W-1:0]      hi_dec;
  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] parent_val;
  logic                  query_read;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_leaves <= USED_LEAVES_RESET;
    end else if (cfg_wr_en) begin
      used_leaves <= cfg_wr_data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_cmd   <= command;
      op_left  <= left_index;
      op_right <= right_bound;
      op_value <= write_value;
    end
  end

  // Leaf count: zero acts as one leaf, and the count saturates at the tree size.
  assign used_w = CMP_W'(used_leaves);
  always_comb begin
    if (used_w == '0) begin
      n_w = CMP_W'(1);
    end else if (used_w > CMP_W'(LEAVES)) begin
      n_w = CMP_W'(LEAVES);
    end else begin
      n_w = used_w;
    end
  end
  assign n_pos = POS_W'(n_w);

  // Clamp the query bounds and move them to the leaf row.
  assign left_w   = CMP_W'(op_left);
  assign right_w  = CMP_W'(op_right);
  assign lo_clamp = (left_w > n_w) ? n_w : left_w;
  assign hi_clamp = (right_w > n_w) ? n_w : right_w;
  assign lo_start = POS_W'(lo_clamp) + n_pos;
  assign hi_start = POS_W'(hi_clamp) + n_pos;
  assign hi_dec   = hi - POS_W'(1);

  // Store value is masked to the node width.
  assign in_val     = VALUE_BITS'(WIDE_W'(op_value));
  assign parent_val = (cur > rdata) ? cur : rdata;
  assign query_read = (cmd.q_lo && lo[0]) || (cmd.q_hi && hi[0]);

  // Memory write port: clearing sweep, leaf store or parent store.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.upd_leaf) begin
      // The update is taken only when the leaf is in range, so lo_start is n + index.
      mem_we    = 1'b1;
      mem_waddr = lo_start[ADDR_W-1:0];
      mem_wdata = in_val;
    end else if (cmd.upd_write) begin
      mem_we    = 1'b1;
      mem_waddr = p >> 1;
      mem_wdata = parent_val;
    end
  end

  // Memory read port: sibling on update, range edges on query.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = p ^ ADDR_W'(1);
    if (cmd.upd_read) begin
      mem_re = 1'b1;
    end else if (cmd.q_lo && lo[0]) begin
      mem_re    = 1'b1;
      mem_raddr = lo[ADDR_W-1:0];
    end else if (cmd.q_hi && hi[0]) begin
      mem_re    = 1'b1;
      mem_raddr = hi_dec[ADDR_W-1:0];
    end
  end

  // Node memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Update climb: current node and its value.
  always_ff @(posedge clk) begin
    if (cmd.upd_leaf) begin
      p   <= lo_start[ADDR_W-1:0];
      cur <= in_val;
    end else if (cmd.upd_write) begin
      p   <= p >> 1;
      cur <= parent_val;
    end
  end

  // Query walk: q_lo may step lo past an odd edge, then q_hi moves both bounds up one level.
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      lo <= lo_start;
      hi <= hi_start;
    end else if (cmd.q_lo) begin
      if (lo[0]) lo <= lo + POS_W'(1);
    end else if (cmd.q_hi) begin
      lo <= lo >> 1;
      hi <= hi >> 1;
    end
  end

  // A query read lands in the next cycle and is folded into the running maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= query_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      best <= '0;
    end else if (pend && (rdata > best)) begin
      best <= rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      max_value <= OUT_W'(WIDE_W'(best));
    end
  end

  // Status to the controller.
  always_comb begin
    status.clear_done  = (clr_addr == ADDR_W'(NODE_COUNT - 1));
    status.is_query    = (op_cmd == CMD_QUERY);
    status.upd_skip    = (left_w >= n_w);
    status.p_root      = (p <= ADDR_W'(1));
    status.range_empty = (lo >= hi);
    status.out_free    = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

/* src/range_max_segment_tree.sv */
// Range-maximum segment tree over up to LEAVES leaves, one request at a time.
// Update: stores an in-range leaf, then reads each sibling and stores each parent to the root.
// Query: each level walked reads its lower edge and then its upper edge through the node
// memory's single read port (at most 11 levels at 1024 leaves); the result may wait for the
// output register. The next request is taken when the last ends.
// Reset (synchronous) clears control state and then sweeps the node memory to zero,
// during which no request is taken.
`default_nettype none

module range_max_segment_tree #(
  parameter int LEAVES     = rmst_pkg::LEAVES_DEF,
  parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rmst_pkg::USED_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rmst_pkg::COMMAND_W-1:0] command,
  input  logic [rmst_pkg::LEFT_W-1:0]    left_index,
  input  logic [rmst_pkg::RIGHT_W-1:0]   right_bound,
  input  logic [rmst_pkg::WVAL_W-1:0]    write_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rmst_pkg::OUT_W-1:0]     max_value
);
  import rmst_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer.
  rmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Node memory, walk registers and output register.
  rmst_datapath #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .command     (command),
    .left_index  (left_index),
    .right_bound (right_bound),
    .write_value (write_value),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .max_value   (max_value)
  );

  // A parent store always follows the read of its sibling.
  assert property (@(posedge clk) disable iff (rst)
    cmd.upd_write |-> $past(cmd.upd_read))
    else $error("parent store without a preceding sibling read");

  // At most one source drives the memory write port.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.upd_leaf, cmd.upd_write}))
    else $error("conflicting memory writes");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result overwrites a pending result");

  // A result appears only through a load of the output register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

endmodule

`default_nettype wire

/* dv/tb_range_max_segment_tree.sv */
`default_nettype none

module tb_range_max_segment_tree;
  timeunit 1ns;
  timeprecision 1ps;

  import rmst_pkg::*;

  localparam int NODE_COUNT = 2 * LEAVES_DEF;

  // Tracks the tree contents and the maxima that outstanding queries must return.
  class range_max_tracker;
    logic [OUT_W-1:0] nodes [0:NODE_COUNT-1];
    logic [USED_W-1:0] leaves_reg;
    logic [OUT_W-1:0] expected_max [$];
    int unsigned mismatches;

    function new();
      foreach (nodes[k]) nodes[k] = '0;
      leaves_reg = USED_LEAVES_RESET;
      mismatches = 0;
    endfunction

    function void set_leaves(logic [USED_W-1:0] value);
      leaves_reg = value;
    endfunction

    function int unsigned pending();
      return expected_max.size();
    endfunction

    // Zero acts as one leaf; anything above the build size saturates.
    function int unsigned active_leaves();
      int unsigned n;
      n = leaves_reg;
      if (n == 0) n = 1;
      if (n > LEAVES_DEF) n = LEAVES_DEF;
      return n;
    endfunction

    // Applies an accepted request to the tree copy; a query queues its answer.
    function void note_request(logic [COMMAND_W-1:0] cmd, logic [LEFT_W-1:0] left,
                               logic [RIGHT_W-1:0] right, logic [WVAL_W-1:0] value);
      int unsigned n;
      int unsigned p;
      int unsigned lo;
      int unsigned hi;
      logic [OUT_W-1:0] best;
      n = active_leaves();
      if (cmd == CMD_UPDATE) begin
        // A leaf outside the leaves in use is left alone.
        if (left >= n) return;
        p = n + left;
        nodes[p] = value;
        while (p > 1) begin
          nodes[p / 2] = (nodes[p] > nodes[p ^ 1]) ? nodes[p] : nodes[p ^ 1];
          p = p / 2;
        end
      end else begin
        // Both bounds clamp to the leaf count; an empty range answers zero.
        lo = left;
        hi = right;
        if (lo > n) lo = n;
        if (hi > n) hi = n;
        lo += n;
        hi += n;
        best = '0;
        while (lo < hi) begin
          if (lo % 2 == 1) begin
            if (nodes[lo] > best) best = nodes[lo];
            lo++;
          end
          if (hi % 2 == 1) begin
            hi--;
            if (nodes[hi] > best) best = nodes[hi];
          end
          lo = lo / 2;
          hi = hi / 2;
        end
        expected_max.push_back(best);
      end
    endfunction

    // Compares one returned maximum with the oldest outstanding query.
    function void check_max(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_max.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: max_value %0d returned with no query outstanding", got);
        return;
      end
      want = expected_max.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: max_value expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [USED_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_ready;
  logic [COMMAND_W-1:0] command;
  logic [LEFT_W-1:0] left_index;
  logic [RIGHT_W-1:0] right_bound;
  logic [WVAL_W-1:0] write_value;
  logic out_valid;
  logic out_ready;
  logic [OUT_W-1:0] max_value;

  range_max_tracker board = new();
  bit quiet_tail = 1'b0;

  range_max_segment_tree DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .left_index  (left_index),
    .right_bound (right_bound),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .max_value   (max_value)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: ready with random stall bursts, steady in the tail.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Every returned maximum is checked as it is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_max(max_value);
    end
  end

  // Hands one request to the block, sometimes after an idle burst.
  task automatic send_request(logic [COMMAND_W-1:0] cmd, logic [LEFT_W-1:0] left,
                              logic [RIGHT_W-1:0] right, logic [WVAL_W-1:0] value);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    left_index <= left;
    right_bound <= right;
    write_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_request(cmd, left, right, value);
  endtask

  // Random request, mostly inside the leaves in use, with some out of range.
  task automatic send_random_request();
    int unsigned n;
    logic [COMMAND_W-1:0] cmd;
    logic [LEFT_W-1:0] left;
    int unsigned right;
    logic [WVAL_W-1:0] value;
    n = board.active_leaves();
    cmd = ($urandom_range(0, 1) == 1) ? CMD_QUERY : CMD_UPDATE;
    if ($urandom_range(0, 9) == 0) left = LEFT_W'($urandom);
    else left = LEFT_W'($urandom_range(0, n - 1));
    case ($urandom_range(0, 7))
      0: right = $urandom_range(0, 2047);
      1: right = left;
      default: right = left + $urandom_range(1, n);
    endcase
    if (right > 2047) right = 2047;
    case ($urandom_range(0, 7))
      0: value = '1;
      1: value = '0;
      2: value = WVAL_W'($urandom_range(0, 15));
      default: value = WVAL_W'($urandom);
    endcase
    send_request(cmd, left, RIGHT_W'(right), value);
  endtask

  // Holds off new requests until every query has answered.
  task automatic wait_for_maxima();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Lets a trailing update finish so the block is idle for a register write.
  task automatic settle_tree();
    wait_for_maxima();
    repeat (32) @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_leaf_count(logic [USED_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_leaves(value);
  endtask

  // Stimulus: directed corners, then random phases over several leaf counts.
  initial begin
    int unsigned phase_cfg [8];
    int unsigned phase_len [8];
    phase_cfg = '{0, 1, 2047, 5, 100, 37, 1000, 1024};
    phase_len = '{30, 40, 70, 60, 70, 60, 90, 80};
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    command <= CMD_UPDATE;
    left_index <= '0;
    right_bound <= '0;
    write_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The node memory clears itself after reset before taking requests.
    settle_tree();
    write_leaf_count(11'd1024);

    // Full-width tree: empty tree, extreme values, edges, empty and inverted ranges.
    send_request(CMD_QUERY, 10'd0, 11'd1024, '0);
    send_request(CMD_UPDATE, 10'd0, 11'd2047, 31'h7FFF_FFFF);
    send_request(CMD_UPDATE, 10'd1023, 11'd0, 31'd1);
    send_request(CMD_UPDATE, 10'd512, 11'd5, 31'd0);
    send_request(CMD_QUERY, 10'd0, 11'd1024, '0);
    send_request(CMD_QUERY, 10'd1, 11'd1024, '0);
    send_request(CMD_QUERY, 10'd1023, 11'd1024, '0);
    send_request(CMD_QUERY, 10'd1023, 11'd2047, '1);
    send_request(CMD_QUERY, 10'd0, 11'd0, '0);
    send_request(CMD_QUERY, 10'd600, 11'd300, '0);
    send_request(CMD_UPDATE, 10'd0, 11'd0, 31'd0);
    send_request(CMD_QUERY, 10'd0, 11'd1, '0);
    send_request(CMD_QUERY, 10'd0, 11'd2047, '0);
    send_request(CMD_UPDATE, 10'd1023, 11'd1024, 31'h7FFF_FFFF);
    send_request(CMD_QUERY, 10'd1022, 11'd1024, '0);
    send_request(CMD_QUERY, 10'd1023, 11'd1023, '0);

    // A zero leaf count acts as one leaf and keeps the old node contents.
    settle_tree();
    write_leaf_count(11'd0);
    send_request(CMD_QUERY, 10'd0, 11'd1, '0);
    send_request(CMD_UPDATE, 10'd0, 11'd0, 31'd5);
    send_request(CMD_UPDATE, 10'd1, 11'd0, 31'd9);
    send_request(CMD_QUERY, 10'd0, 11'd2047, '0);
    send_request(CMD_QUERY, 10'd1, 11'd2, '0);
    send_request(CMD_QUERY, 10'd1023, 11'd0, '0);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        settle_tree();
        write_leaf_count(USED_W'(phase_cfg[p]));
      end
      if (p == 7) quiet_tail = 1'b1;
      for (int i = 0; i < phase_len[p]; i++) begin
        if (p == 2 && i == phase_len[p] / 2) wait_for_maxima();
        send_random_request();
      end
    end

    // Drain, then allow a trailing update to finish.
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
